>>> hw/rtl/iatp_pkg.sv
// Shared types and constants for the IP address text parser.
// Holds the character class beat, parser phase enum and result beat.
// No dependencies.
package iatp_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [4:0] WP_GROUP_MAX = 5'd14;
    localparam logic [4:0] WP_QUAD_MAX  = 5'd12;
    localparam logic [4:0] ADDR_BYTES   = 5'd16;
    localparam logic [7:0] OCTET_MAX    = 8'd255;

    typedef enum logic [2:0] {
        PH_START       = 3'd0,
        PH_LEAD_COLON  = 3'd1,
        PH_AFTER_GAP   = 3'd2,
        PH_IN_GROUP    = 3'd3,
        PH_AFTER_COLON = 3'd4,
        PH_IN_QUAD     = 3'd5
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic       term;
        logic       dec_ok;
        logic       hex_ok;
        logic       dot;
        logic       colon;
        logic [3:0] nib;
    } cls_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } result_t;

endpackage

>>> hw/rtl/iatp_front.sv
// Front end: classifies each text byte and queues the class beat.
// Depends on iatp_pkg.
module iatp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          mode,
    input  logic [7:0]    character,
    output logic          item_valid,
    output iatp_pkg::cls_t item,
    input  logic          item_take
);
    import iatp_pkg::*;

    cls_t       cls;
    logic [7:0] hex_off;
    cls_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push_ok, pop_ok;

    always_comb
    begin
        cls.mode   = mode;
        cls.term   = (character == CH_NUL);
        cls.dot    = (character == CH_DOT);
        cls.colon  = (character == CH_COLON);
        cls.dec_ok = (character inside {[CH_0:CH_9]});
        cls.hex_ok = 1'b1;
        hex_off    = 8'h00;
        if (character inside {[CH_0:CH_9]})
        begin
            hex_off = character - CH_0;
        end
        else if (character inside {[CH_LA:CH_LF]})
        begin
            hex_off = character - CH_LA + 8'd10;
        end
        else if (character inside {[CH_UA:CH_UF]})
        begin
            hex_off = character - CH_UA + 8'd10;
        end
        else
        begin
            cls.hex_ok = 1'b0;
        end
        cls.nib = hex_off[3:0];
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign pop_ok     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("front queue count out of range");
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop_ok |=> cnt_reg == 2'd2) else $error("front queue lost an entry");
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("front queue pointers out of step");

endmodule

>>> hw/rtl/iatp_back.sv
// Back end: parser state machine, address finish stage and result queue.
// Depends on iatp_pkg.
module iatp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  iatp_pkg::cls_t item,
    output logic           item_take,
    output logic           empty,
    input  logic           pop,
    output logic           ok,
    output logic [63:0]    addr_high,
    output logic [63:0]    addr_low
);
    import iatp_pkg::*;

    // parser state
    logic [7:0]  bytes_reg [16];
    logic [7:0]  bytes_next [16];
    logic [4:0]  wp_reg, wp_next;
    logic        gap_reg, gap_next;
    logic [4:0]  gpos_reg, gpos_next;
    logic [15:0] gh_reg, gh_next;
    logic [7:0]  dec_reg, dec_next;
    logic [2:0]  dc_reg, dc_next;
    logic        lz_reg, lz_next;
    logic [2:0]  qp_reg, qp_next;
    phase_t      phase_reg, phase_next;
    logic        failed_reg, failed_next;
    logic        fam_reg, fam_next;

    // finish stage
    logic        f_valid_reg, f_valid_next;
    logic        f_good_reg;
    logic        f_fam_reg;
    logic        f_gap_reg;
    logic [4:0]  f_gpos_reg;
    logic [4:0]  f_wp_reg;
    logic [7:0]  f_bytes_reg [16];
    logic        fin_good;
    logic [4:0]  fin_wp;
    logic [7:0]  fin_bytes [16];

    // result queue
    result_t     oq_reg [2];
    logic        oq_wr_reg, oq_rd_reg;
    logic [1:0]  oq_cnt_reg;
    logic        oq_full, f_ready, f_move, pop_ok;
    result_t     f_res;

    phase_t      eph;
    logic        start_colon;
    logic        cg;
    logic [3:0]  qidx;
    logic [11:0] dmul;
    logic [10:0] g2q_v;
    logic        g2q_bad;
    logic [3:0]  nib0, nib1, nib2;

    assign oq_full   = (oq_cnt_reg == 2'd2);
    assign f_ready   = !f_valid_reg || !oq_full;
    assign f_move    = f_valid_reg && !oq_full;
    assign item_take = item_valid && (!item.term || f_ready);
    assign pop_ok    = pop && (oq_cnt_reg != 2'd0);

    assign start_colon = (phase_reg == PH_START) && item.mode && item.colon;
    assign eph = (phase_reg != PH_START) ? phase_reg
               : (item.mode ? PH_IN_GROUP : PH_IN_QUAD);

    assign cg   = (dc_reg != 3'd0) && !(lz_reg && dc_reg > 3'd1);
    assign qidx = wp_reg[3:0] + {1'b0, qp_reg};
    assign dmul = {4'd0, dec_reg} * 12'd10 + {8'd0, item.nib};
    assign nib0 = gh_reg[3:0];
    assign nib1 = gh_reg[7:4];
    assign nib2 = gh_reg[11:8];

    always_comb
    begin
        case (dc_reg)
            3'd1:    g2q_v = {7'd0, nib0};
            3'd2:    g2q_v = {7'd0, nib1} * 11'd10 + {7'd0, nib0};
            default: g2q_v = {7'd0, nib2} * 11'd100 + {7'd0, nib1} * 11'd10
                             + {7'd0, nib0};
        endcase
        g2q_bad = (dc_reg == 3'd0) || (dc_reg > 3'd3) || (wp_reg > WP_QUAD_MAX)
                || (nib0 > 4'd9)
                || (dc_reg >= 3'd2 && nib1 > 4'd9)
                || (dc_reg >= 3'd3 && nib2 > 4'd9)
                || (dc_reg == 3'd2 && nib1 == 4'd0)
                || (dc_reg == 3'd3 && nib2 == 4'd0)
                || (g2q_v > {3'd0, OCTET_MAX});
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (item_take)
        begin
            if (item.term)
            begin
                phase_next = PH_START;
            end
            else if (start_colon)
            begin
                phase_next = PH_LEAD_COLON;
            end
            else if (!failed_reg)
            begin
                case (eph)
                    PH_LEAD_COLON:  phase_next = PH_AFTER_GAP;
                    PH_AFTER_GAP,
                    PH_AFTER_COLON,
                    PH_IN_GROUP:
                    begin
                        if (item.colon)
                        begin
                            phase_next = (eph == PH_IN_GROUP) ? PH_AFTER_COLON
                                                             : PH_AFTER_GAP;
                        end
                        else if (item.dot && !item.hex_ok)
                        begin
                            phase_next = PH_IN_QUAD;
                        end
                        else
                        begin
                            phase_next = PH_IN_GROUP;
                        end
                    end
                    PH_IN_QUAD:     phase_next = PH_IN_QUAD;
                    default:        phase_next = phase_reg;
                endcase
            end
        end
    end

    // datapath and status
    always_comb
    begin
        logic do_grp;
        do_grp      = 1'b0;
        bytes_next  = bytes_reg;
        wp_next     = wp_reg;
        gap_next    = gap_reg;
        gpos_next   = gpos_reg;
        gh_next     = gh_reg;
        dec_next    = dec_reg;
        dc_next     = dc_reg;
        lz_next     = lz_reg;
        qp_next     = qp_reg;
        failed_next = failed_reg;
        fam_next    = fam_reg;
        fin_good    = 1'b0;
        fin_wp      = wp_reg;
        fin_bytes   = bytes_reg;

        if (!failed_reg && phase_reg != PH_START)
        begin
            if (!fam_reg)
            begin
                if (phase_reg == PH_IN_QUAD && qp_reg == 3'd3 && cg)
                begin
                    fin_good = 1'b1;
                    fin_bytes[qidx] = dec_reg;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_AFTER_GAP: fin_good = 1'b1;
                    PH_IN_GROUP:
                    begin
                        if (wp_reg <= WP_GROUP_MAX)
                        begin
                            fin_good = 1'b1;
                            fin_bytes[wp_reg[3:0]]        = gh_reg[15:8];
                            fin_bytes[wp_reg[3:0] + 4'd1] = gh_reg[7:0];
                            fin_wp = wp_reg + 5'd2;
                        end
                    end
                    PH_IN_QUAD:
                    begin
                        if (qp_reg == 3'd3 && cg)
                        begin
                            fin_good = 1'b1;
                            fin_bytes[qidx] = dec_reg;
                            fin_wp = wp_reg + 5'd4;
                        end
                    end
                    default: fin_good = 1'b0;
                endcase
            end
        end

        if (item_take)
        begin
            if (item.term)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    bytes_next[i] = 8'h00;
                end
                wp_next     = 5'd0;
                gap_next    = 1'b0;
                gpos_next   = 5'd0;
                gh_next     = 16'h0000;
                dec_next    = 8'h00;
                dc_next     = 3'd0;
                lz_next     = 1'b0;
                qp_next     = 3'd0;
                failed_next = 1'b0;
            end
            else
            begin
                if (phase_reg == PH_START)
                begin
                    fam_next = item.mode;
                end
                if (!failed_reg && !start_colon)
                begin
                    case (eph)
                        PH_LEAD_COLON:
                        begin
                            if (item.colon)
                            begin
                                gap_next  = 1'b1;
                                gpos_next = 5'd0;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        PH_AFTER_GAP:
                        begin
                            if (item.colon)
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                do_grp = 1'b1;
                            end
                        end
                        PH_AFTER_COLON:
                        begin
                            if (item.colon)
                            begin
                                if (gap_reg)
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    gap_next  = 1'b1;
                                    gpos_next = wp_reg;
                                end
                            end
                            else
                            begin
                                do_grp = 1'b1;
                            end
                        end
                        PH_IN_GROUP: do_grp = 1'b1;
                        PH_IN_QUAD:
                        begin
                            if (item.dec_ok)
                            begin
                                if (dc_reg == 3'd0)
                                begin
                                    lz_next = (item.nib == 4'd0);
                                end
                                dc_next = dc_reg + 3'd1;
                                if (dc_reg >= 3'd3 || dmul > {4'd0, OCTET_MAX})
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    dec_next = dmul[7:0];
                                end
                            end
                            else if (item.dot)
                            begin
                                if (cg)
                                begin
                                    bytes_next[qidx] = dec_reg;
                                end
                                dec_next = 8'h00;
                                dc_next  = 3'd0;
                                lz_next  = 1'b0;
                                if (!cg || qp_reg >= 3'd3)
                                begin
                                    failed_next = 1'b1;
                                end
                                else
                                begin
                                    qp_next = qp_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        default: failed_next = 1'b1;
                    endcase
                end
                if (do_grp)
                begin
                    if (item.hex_ok)
                    begin
                        if (dc_reg >= 3'd4)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            gh_next = {gh_reg[11:0], item.nib};
                            dc_next = dc_reg + 3'd1;
                        end
                    end
                    else if (item.dot)
                    begin
                        if (g2q_bad)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            bytes_next[wp_reg[3:0]] = g2q_v[7:0];
                            qp_next  = 3'd1;
                            gh_next  = 16'h0000;
                            dc_next  = 3'd0;
                            dec_next = 8'h00;
                            lz_next  = 1'b0;
                        end
                    end
                    else if (item.colon)
                    begin
                        if (wp_reg > WP_GROUP_MAX)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            bytes_next[wp_reg[3:0]]        = gh_reg[15:8];
                            bytes_next[wp_reg[3:0] + 4'd1] = gh_reg[7:0];
                            wp_next = wp_reg + 5'd2;
                            gh_next = 16'h0000;
                            dc_next = 3'd0;
                        end
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                bytes_reg[i] <= 8'h00;
            end
            wp_reg     <= 5'd0;
            gap_reg    <= 1'b0;
            gpos_reg   <= 5'd0;
            gh_reg     <= 16'h0000;
            dec_reg    <= 8'h00;
            dc_reg     <= 3'd0;
            lz_reg     <= 1'b0;
            qp_reg     <= 3'd0;
            phase_reg  <= PH_START;
            failed_reg <= 1'b0;
            fam_reg    <= 1'b0;
        end
        else
        begin
            bytes_reg  <= bytes_next;
            wp_reg     <= wp_next;
            gap_reg    <= gap_next;
            gpos_reg   <= gpos_next;
            gh_reg     <= gh_next;
            dec_reg    <= dec_next;
            dc_reg     <= dc_next;
            lz_reg     <= lz_next;
            qp_reg     <= qp_next;
            phase_reg  <= phase_next;
            failed_reg <= failed_next;
            fam_reg    <= fam_next;
        end
    end

    // finish stage: holds the closed-out string while the parser moves on
    assign f_valid_next = (item_take && item.term) ? 1'b1
                        : (f_move ? 1'b0 : f_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item.term)
        begin
            f_good_reg  <= fin_good;
            f_fam_reg   <= fam_reg;
            f_gap_reg   <= gap_reg;
            f_gpos_reg  <= gpos_reg;
            f_wp_reg    <= fin_wp;
            f_bytes_reg <= fin_bytes;
        end
    end

    // gap expansion: groups after the gap slide to the end of the address
    always_comb
    begin
        logic [7:0] xb [16];
        logic       okv;
        logic [5:0] jw;
        okv = f_good_reg;
        for (int j = 0; j < 16; j++)
        begin
            jw = 6'(j) + {1'b0, f_wp_reg};
            if (!f_gap_reg || 5'(j) < f_gpos_reg)
            begin
                xb[j] = f_bytes_reg[j];
            end
            else if (jw >= 6'd16 + {1'b0, f_gpos_reg})
            begin
                xb[j] = f_bytes_reg[jw[3:0]];
            end
            else
            begin
                xb[j] = 8'h00;
            end
        end
        if (f_fam_reg)
        begin
            if (f_gap_reg)
            begin
                okv = f_good_reg && (f_wp_reg < ADDR_BYTES) && (f_gpos_reg <= f_wp_reg);
            end
            else
            begin
                okv = f_good_reg && (f_wp_reg == ADDR_BYTES);
            end
        end
        f_res.ok = okv;
        if (!okv)
        begin
            f_res.addr_high = 64'd0;
            f_res.addr_low  = 64'd0;
        end
        else if (!f_fam_reg)
        begin
            f_res.addr_high = 64'd0;
            f_res.addr_low  = {32'd0, xb[0], xb[1], xb[2], xb[3]};
        end
        else
        begin
            f_res.addr_high = {xb[0], xb[1], xb[2], xb[3], xb[4], xb[5], xb[6], xb[7]};
            f_res.addr_low  = {xb[8], xb[9], xb[10], xb[11], xb[12], xb[13], xb[14],
                               xb[15]};
        end
    end

    // result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            oq_wr_reg  <= f_move ? ~oq_wr_reg : oq_wr_reg;
            oq_rd_reg  <= pop_ok ? ~oq_rd_reg : oq_rd_reg;
            oq_cnt_reg <= oq_cnt_reg + {1'b0, f_move} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_move)
        begin
            oq_reg[oq_wr_reg] <= f_res;
        end
    end

    assign empty     = (oq_cnt_reg == 2'd0);
    assign ok        = oq_reg[oq_rd_reg].ok;
    assign addr_high = oq_reg[oq_rd_reg].addr_high;
    assign addr_low  = oq_reg[oq_rd_reg].addr_low;

    a_oq_range: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg != 2'd3) else $error("result queue count out of range");
    a_f_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid_reg && oq_full |=> f_valid_reg) else $error("finish stage dropped a result");
    a_wp_even: assert property (@(posedge clk) disable iff (!rst_n)
        !wp_reg[0]) else $error("write position odd");
    a_gap_v6: assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg |-> fam_reg) else $error("gap marked in IPv4 string");

endmodule

>>> hw/rtl/ip_address_text_parser.sv
// Top level of the IP address text parser.
// Instantiates iatp_front and iatp_back; depends on iatp_pkg.
//
// Usage:
//   Input channel is a queue write side: drive mode and character with push;
//   a beat is taken on a clock edge where push is high and full is low. Each
//   beat is one byte of address text; a zero byte ends the string. mode is
//   taken from the first byte of each string (0 IPv4, 1 IPv6).
//   Result channel is a queue read side: while empty is low, ok, addr_high
//   and addr_low show the oldest result; it is taken when pop is high.
//   One result comes out per zero byte; ok low means malformed text and the
//   address fields are then zero.
// Throughput: one byte per cycle, sustained, as long as results are drained.
// Path: a terminating byte, once taken, moves from the front queue into the
//   parser and finish stage, then from the finish stage with gap expansion
//   into the result queue. The front and result queues are two deep each.
// Stall: when the result queue fills, the finish stage holds, the parser
//   stops taking terminators, and the front queue backs up to full. Bytes
//   other than terminators keep flowing until a terminator blocks.
// Reset: rst_n low empties all queues and returns the parser to the start of
//   a string; no clearing pass is needed.
module ip_address_text_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  character,
    output logic        empty,
    input  logic        pop,
    output logic        ok,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low
);
    import iatp_pkg::*;

    cls_t item;
    logic item_valid;
    logic item_take;

    // classify and queue incoming bytes
    iatp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .character  (character),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // parse, finish and queue results
    iatp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .ok         (ok),
        .addr_high  (addr_high),
        .addr_low   (addr_low)
    );

endmodule

>>> tb/sv/iatp_scoreboard.sv
// Address parse predictor and result scoreboard for the IP address text parser tb.
// Depends on iatp_pkg (phase enum, result type and character constants).
package iatp_sb_pkg;
    import iatp_pkg::*;

    class iatp_scoreboard;
        logic [7:0]  abyte [16];
        logic [5:0]  wpos;
        logic        gap_on;
        logic [5:0]  gap_at;
        logic [15:0] grp;
        int unsigned dval;
        int unsigned ndig;
        logic        lz;
        int unsigned part;
        phase_t      ph;
        logic        bad;
        logic        fam;
        result_t     pending[$];
        int          errors;

        function new();
            errors = 0;
            fam = 0;
            clear();
        endfunction

        function void clear();
            foreach (abyte[i]) abyte[i] = 8'h00;
            wpos = 0; gap_on = 0; gap_at = 0; grp = 0;
            dval = 0; ndig = 0; lz = 0; part = 0;
            ph = PH_START; bad = 0;
        endfunction

        function int hexval(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9) return c - CH_0;
            if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
            if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
            return -1;
        endfunction

        function bit close_part();
            bit good;
            good = ndig > 0 && !(lz && ndig > 1);
            if (good) abyte[(wpos + part) & 15] = dval[7:0];
            dval = 0; ndig = 0; lz = 0;
            return good;
        endfunction

        function void quad_char(logic [7:0] c);
            int unsigned v;
            if (c >= CH_0 && c <= CH_9) begin
                if (ndig == 0) lz = (c == CH_0);
                v = dval * 10 + (c - CH_0);
                ndig++;
                if (ndig > 3 || v > 255) begin bad = 1; return; end
                dval = v;
            end else if (c == CH_DOT) begin
                if (!close_part() || part >= 3) begin bad = 1; return; end
                part++;
            end else bad = 1;
        endfunction

        function bit end_group();
            if (wpos > 14) return 0;
            abyte[wpos & 15] = grp[15:8];
            abyte[(wpos + 1) & 15] = grp[7:0];
            wpos += 2; grp = 0; ndig = 0;
            return 1;
        endfunction

        function void group_to_quad();
            int unsigned v, nib;
            v = 0;
            if (ndig < 1 || ndig > 3 || wpos > 12) begin bad = 1; return; end
            for (int i = ndig; i > 0; i--) begin
                nib = (grp >> (4 * (i - 1))) & 15;
                if (nib > 9) begin bad = 1; return; end
                v = v * 10 + nib;
            end
            if ((ndig > 1 && ((grp >> (4 * (ndig - 1))) & 15) == 0) || v > 255) begin
                bad = 1; return;
            end
            abyte[wpos & 15] = v[7:0];
            part = 1; grp = 0; ndig = 0; dval = 0; lz = 0;
            ph = PH_IN_QUAD;
        endfunction

        function void group_char(logic [7:0] c);
            int d;
            d = hexval(c);
            if (d >= 0) begin
                if (ndig >= 4) begin bad = 1; return; end
                grp = (grp << 4) | d[3:0];
                ndig++;
            end else if (c == CH_DOT) group_to_quad();
            else if (c == CH_COLON) begin
                if (!end_group()) begin bad = 1; return; end
                ph = PH_AFTER_COLON;
            end else bad = 1;
        endfunction

        function bit finish_v6();
            logic [7:0] tmp [16];
            int unsigned tail;
            case (ph)
                PH_AFTER_GAP: ;
                PH_IN_GROUP: if (!end_group()) return 0;
                PH_IN_QUAD: begin
                    if (part != 3 || !close_part()) return 0;
                    wpos += 4;
                end
                default: return 0;
            endcase
            if (gap_on) begin
                if (wpos >= 16 || gap_at > wpos) return 0;
                tail = wpos - gap_at;
                foreach (tmp[i]) tmp[i] = 8'h00;
                for (int i = 0; i < gap_at; i++) tmp[i] = abyte[i];
                for (int i = 0; i < tail; i++) tmp[16 - tail + i] = abyte[(gap_at + i) & 15];
                abyte = tmp;
                return 1;
            end
            return wpos == 16;
        endfunction

        // note one accepted input beat
        function void note_char(logic m, logic [7:0] c);
            result_t r;
            if (c == CH_NUL) begin
                r = '0;
                if (!bad && ph != PH_START)
                    r.ok = fam ? finish_v6()
                               : (ph == PH_IN_QUAD && part == 3 && close_part());
                if (r.ok) begin
                    if (!fam) for (int i = 0; i < 4; i++)
                        r.addr_low = (r.addr_low << 8) | abyte[i];
                    else begin
                        for (int i = 0; i < 8; i++) r.addr_high = (r.addr_high << 8) | abyte[i];
                        for (int i = 8; i < 16; i++) r.addr_low = (r.addr_low << 8) | abyte[i];
                    end
                end
                pending.push_back(r);
                clear();
                return;
            end
            if (ph == PH_START) begin
                fam = m;
                if (!fam) ph = PH_IN_QUAD;
                else if (c == CH_COLON) begin ph = PH_LEAD_COLON; return; end
                else ph = PH_IN_GROUP;
            end
            if (bad) return;
            case (ph)
                PH_LEAD_COLON: begin
                    if (c != CH_COLON) bad = 1;
                    else begin gap_on = 1; gap_at = 0; ph = PH_AFTER_GAP; end
                end
                PH_AFTER_GAP: begin
                    if (c == CH_COLON) bad = 1;
                    else begin ph = PH_IN_GROUP; group_char(c); end
                end
                PH_AFTER_COLON: begin
                    if (c == CH_COLON) begin
                        if (gap_on) bad = 1;
                        else begin gap_on = 1; gap_at = wpos; ph = PH_AFTER_GAP; end
                    end else begin ph = PH_IN_GROUP; group_char(c); end
                end
                PH_IN_GROUP: group_char(c);
                PH_IN_QUAD: quad_char(c);
                default: bad = 1;
            endcase
        endfunction

        // check one accepted result beat against the oldest expectation
        function void check_result(logic o, logic [63:0] hi, logic [63:0] lo);
            result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat ok=%0b", o);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (o !== e.ok) begin
                $error("ok: expected %0b actual %0b", e.ok, o); errors++;
            end
            if (hi !== e.addr_high) begin
                $error("addr_high: expected %h actual %h", e.addr_high, hi); errors++;
            end
            if (lo !== e.addr_low) begin
                $error("addr_low: expected %h actual %h", e.addr_low, lo); errors++;
            end
        endfunction
    endclass
endpackage

>>> tb/sv/ip_address_text_parser_tb.sv
// Testbench top for ip_address_text_parser: directed and random address text,
// checked against the scoreboard predictor. Depends on iatp_pkg, iatp_sb_pkg.
module ip_address_text_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import iatp_pkg::*;
    import iatp_sb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        mode;
    logic [7:0]  character;
    logic        empty;
    logic        pop;
    logic        ok;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    // idle rates in percent for each side
    int unsigned send_idle;
    int unsigned recv_idle;
    iatp_scoreboard sb;

    ip_address_text_parser dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .mode(mode),
        .character(character), .empty(empty), .pop(pop), .ok(ok),
        .addr_high(addr_high), .addr_low(addr_low)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Safety net: far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("FAIL ip_address_text_parser");
        $finish;
    end

    // Result side: pop decided at the falling edge, checked at the rising edge.
    initial
    begin
        pop = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty) sb.check_result(ok, addr_high, addr_low);
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Push one beat; holds push high across back-to-back beats.
    task automatic send_beat(input logic m, input logic [7:0] c);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(negedge clk);
        end
        push <= 1;
        mode <= m;
        character <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_char(m, c);
        @(negedge clk);
    endtask

    task automatic send_text(input logic m, input string s);
        for (int i = 0; i < s.len(); i++) send_beat(m, s[i]);
        send_beat(m, CH_NUL);
    endtask

    function automatic string hex_group();
        string g, digits;
        int n;
        digits = "0123456789abcdefABCDEF";
        n = $urandom_range(1, 4);
        g = "";
        for (int i = 0; i < n; i++)
            g = {g, string'(digits[$urandom_range(21)])};
        return g;
    endfunction

    function automatic string dec_part();
        int unsigned v;
        v = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom_range(255);
        return $sformatf("%0d", v);
    endfunction

    function automatic string dotted();
        return {dec_part(), ".", dec_part(), ".", dec_part(), ".", dec_part()};
    endfunction

    // Well-formed IPv6 text with random gap position and optional dotted tail.
    function automatic string v6_text();
        string s;
        int total, gap;
        bit tail;
        tail = $urandom_range(3) == 0;
        total = tail ? 6 : 8;
        gap = ($urandom_range(2) == 0) ? -1 : $urandom_range(total);
        s = "";
        if (gap < 0)
        begin
            for (int i = 0; i < total; i++)
            begin
                if (i != 0) s = {s, ":"};
                s = {s, hex_group()};
            end
            if (tail) s = {s, ":", dotted()};
        end
        else
        begin
            int pre, post;
            pre = $urandom_range(gap);
            post = $urandom_range(total - 1 - pre < 0 ? 0 : total - 1 - pre);
            for (int i = 0; i < pre; i++)
            begin
                if (i != 0) s = {s, ":"};
                s = {s, hex_group()};
            end
            s = {s, "::"};
            for (int i = 0; i < post; i++)
            begin
                if (i != 0) s = {s, ":"};
                s = {s, hex_group()};
            end
            if (tail)
            begin
                if (post != 0) s = {s, ":"};
                s = {s, dotted()};
            end
        end
        return s;
    endfunction

    // Damage a good string: replace, insert or drop one character.
    function automatic string mangle(input string s);
        string junk;
        int p;
        junk = ":.0fgG9 x";
        if (s.len() == 0) return s;
        p = $urandom_range(s.len() - 1);
        case ($urandom_range(2))
            0: s[p] = junk[$urandom_range(8)];
            1: s = {s.substr(0, p - 1), string'(junk[$urandom_range(8)]),
                    s.substr(p, s.len() - 1)};
            default: s = {s.substr(0, p - 1), s.substr(p + 1, s.len() - 1)};
        endcase
        return s;
    endfunction

    task automatic random_string();
        int kind;
        logic m;
        kind = $urandom_range(99);
        m = 1'($urandom_range(1));
        if (kind < 70)
            send_text(m, m ? v6_text() : dotted());
        else if (kind < 88)
            send_text(m, mangle(m ? v6_text() : dotted()));
        else
        begin
            // raw byte noise, every bit of mode and character exercised
            int n;
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_beat(1'($urandom_range(1)), 8'($urandom_range(1, 255)));
            send_beat(1'($urandom_range(1)), CH_NUL);
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        rst_n = 0;
        push = 0;
        mode = 0;
        character = 0;
        send_idle = 6;
        recv_idle = 65;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes and the documented corner cases
        send_beat(1'b0, CH_NUL);                 // empty string
        send_text(1'b0, "255.255.255.255");
        send_text(1'b0, "0.0.0.0");
        send_text(1'b0, "01.2.3.4");             // leading zero
        send_text(1'b0, "256.1.1.1");
        send_text(1'b0, "1.2.3.4.");             // trailing dot
        send_text(1'b0, "1.2.3.4\377");          // bytes after a fault
        send_text(1'b1, "::");
        send_text(1'b1, "ffff:FFFF:0:1:2:3:4:5");
        send_text(1'b1, "1::2:");                // trailing single colon
        send_text(1'b1, ":1::2");                // single leading colon
        send_text(1'b1, "1::2::3");              // second gap
        send_text(1'b1, "1:::2");
        send_text(1'b1, "1:2:3:4::5:6:7:8");     // gap with full address
        send_text(1'b1, "::ffff:1.2.3.4");
        send_text(1'b1, "1:2:3:4:5:6:1.2.3.4");
        send_text(1'b1, "1:2:3:4:5:6:7:1.2.3.4"); // tail too late
        send_text(1'b1, "::a.2.3.4");            // hex letter in tail
        send_text(1'b1, "12345::");              // long group
        send_text(1'b1, "1::2.3.4");

        // random: three idling phases of eight strings each, then four more strings
        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 6 : (ph == 1) ? 65 : 0;
            recv_idle = (ph == 0) ? 65 : (ph == 1) ? 6 : 0;
            for (int k = 0; k < 8; k++) random_string();
        end
        while (sent < 4)
        begin
            random_string();
            sent++;
        end
        push <= 0;

        fork
            begin
                while (sb.pending.size() != 0) @(posedge clk);
                repeat (20) @(posedge clk);
            end
            begin
                repeat (200000) @(posedge clk);
                $display("FAIL ip_address_text_parser");
                $finish;
            end
        join_any
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS ip_address_text_parser");
        else
            $display("FAIL ip_address_text_parser");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/iatp_pkg.sv
hw/rtl/iatp_front.sv
hw/rtl/iatp_back.sv
hw/rtl/ip_address_text_parser.sv
tb/sv/iatp_scoreboard.sv
tb/sv/ip_address_text_parser_tb.sv
